>>> rtl/rcid_pkg.sv
// Shared definitions for the reference-counted id allocator.
// Holds the command and status codes used on the stream ports.
// No dependencies.
package rcid_pkg;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam int STATUS_BITS = 3;
    typedef logic [STATUS_BITS-1:0] status_t;

    localparam status_t ST_NEW      = 3'd0;
    localparam status_t ST_EXISTING = 3'd1;
    localparam status_t ST_FREED    = 3'd2;
    localparam status_t ST_HELD     = 3'd3;
    localparam status_t ST_FULL     = 3'd4;
    localparam status_t ST_UNKNOWN  = 3'd5;
    localparam status_t ST_OVERFLOW = 3'd6;

    // Fixed widths of the result fields on the output stream.
    localparam int OUT_ID_BITS    = 6;
    localparam int OUT_COUNT_BITS = 16;

endpackage

>>> rtl/rcid_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module rcid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/refcounted_id_allocator.sv
// Reference-counted id allocator: top level.
// Depends on rcid_pkg and rcid_ram.
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the command (acquire or
//   release) and s_tdata the requester handle. Every request gives exactly one
//   result transfer on the m_ stream: m_tuser carries the status and m_tdata
//   the assigned id and the reference count after the request.
//   A request walks the handle table one entry per cycle through a single
//   shared comparator, looking for the first valid entry holding the handle.
//   The walk stops at the first match, or after the last entry when nothing
//   matches, so an early match gives an earlier result. s_tready is high only
//   in idle and rises again as the result is presented, so the block takes a new
//   request only once the last one has reached the output register.
//   The result waits in an output register; if the receiver stalls, the next
//   request may still be accepted and is held back only at its final step
//   until the waiting result has been taken.
//   Reset (aresetn low, synchronous) empties the table and fills the free
//   stack so that ids 0, 1, 2 and so on are handed out first. No clearing
//   pass is needed; the block accepts requests as soon as reset is released.
module refcounted_id_allocator
    import rcid_pkg::*;
#(
    parameter int MAX_IDS     = 64,
    parameter int HANDLE_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] requester_handle
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] assigned_id, [21:6] ref_count, [23:22] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int IDW = $clog2(MAX_IDS);
    localparam int FCW = $clog2(MAX_IDS + 1);
    localparam int HW  = (HANDLE_BITS > 32) ? 32 : HANDLE_BITS;
    localparam int CW  = COUNT_BITS;

    localparam logic [IDW-1:0] LAST_ID   = IDW'(MAX_IDS - 1);
    localparam logic [FCW-1:0] ALL_FREE  = FCW'(MAX_IDS);
    localparam logic [CW-1:0]  COUNT_MAX = {CW{1'b1}};

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic               cmd_reg;
    logic [HW-1:0]      handle_reg;
    logic [IDW-1:0]     scan_idx_reg, scan_idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDW-1:0]     cmp_idx_reg;
    logic               found_reg, found_next;
    logic [IDW-1:0]     hit_idx_reg, hit_idx_next;
    logic [CW-1:0]      hit_cnt_reg, hit_cnt_next;
    logic [MAX_IDS-1:0] valid_reg, valid_next;
    logic [FCW-1:0]     fc_reg, fc_next;
    // Lowest value the free count has reached; stack slots below it still
    // hold their reset contents and are never read from the RAM.
    logic [FCW-1:0]     low_mark_reg, low_mark_next;

    logic [IDW-1:0]     res_id_reg, res_id_next;
    status_t            res_status_reg, res_status_next;
    logic [CW-1:0]      res_cnt_reg, res_cnt_next;

    logic               out_vld_reg;
    logic [IDW-1:0]     out_id_reg;
    status_t            out_status_reg;
    logic [CW-1:0]      out_cnt_reg;

    logic [HW-1:0]      ram_handle_rd;
    logic [CW-1:0]      ram_count_rd;
    logic [IDW-1:0]     ram_stack_rd;

    logic               handle_we;
    logic               count_we;
    logic [IDW-1:0]     count_waddr;
    logic [CW-1:0]      count_wdata;
    logic               stack_we;

    logic [IDW-1:0]     top_slot;
    logic [IDW-1:0]     pop_id;
    logic               match;
    logic               accept;
    logic               out_free;
    logic               do_pop;
    logic [CW-1:0]      dec_cnt;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_vld_reg || m_tready;

    assign top_slot = IDW'(fc_reg - FCW'(1));
    assign pop_id   = (FCW'(top_slot) < low_mark_reg) ? (LAST_ID - top_slot) : ram_stack_rd;
    assign match    = cmp_vld_reg && valid_reg[cmp_idx_reg] && (ram_handle_rd == handle_reg);
    assign do_pop   = (state_reg == S_DECIDE) && (cmd_reg == CMD_ACQUIRE) && !found_reg
                      && (fc_reg != '0);
    assign dec_cnt  = (hit_cnt_reg != '0) ? (hit_cnt_reg - CW'(1)) : hit_cnt_reg;

    rcid_ram #(.WIDTH(HW), .DEPTH(MAX_IDS)) u_handle_ram (
        .clk   (aclk),
        .we    (handle_we),
        .waddr (pop_id),
        .wdata (handle_reg),
        .raddr (scan_idx_reg),
        .rdata (ram_handle_rd)
    );

    rcid_ram #(.WIDTH(CW), .DEPTH(MAX_IDS)) u_count_ram (
        .clk   (aclk),
        .we    (count_we),
        .waddr (count_waddr),
        .wdata (count_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_count_rd)
    );

    rcid_ram #(.WIDTH(IDW), .DEPTH(MAX_IDS)) u_stack_ram (
        .clk   (aclk),
        .we    (stack_we),
        .waddr (IDW'(fc_reg)),
        .wdata (hit_idx_reg),
        .raddr (top_slot),
        .rdata (ram_stack_rd)
    );

    always_comb begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = 1'b0;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        valid_next      = valid_reg;
        fc_next         = fc_reg;
        low_mark_next   = low_mark_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        res_cnt_next    = res_cnt_reg;
        handle_we       = 1'b0;
        count_we        = 1'b0;
        count_waddr     = hit_idx_reg;
        count_wdata     = hit_cnt_reg;
        stack_we        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                // Read data is registered and lags its address into the next cycle.
                cmp_vld_next = 1'b1;
                if (scan_idx_reg != LAST_ID) begin
                    scan_idx_next = scan_idx_reg + IDW'(1);
                end
                if (match) begin
                    found_next   = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_cnt_next = ram_count_rd;
                    cmp_vld_next = 1'b0;
                    state_next   = S_DECIDE;
                end else if (cmp_vld_reg && cmp_idx_reg == LAST_ID) begin
                    cmp_vld_next = 1'b0;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next   = S_OUT;
                res_id_next  = '0;
                res_cnt_next = '0;
                if (cmd_reg == CMD_ACQUIRE) begin
                    if (found_reg) begin
                        if (hit_cnt_reg == COUNT_MAX) begin
                            res_status_next = ST_OVERFLOW;
                            res_cnt_next    = hit_cnt_reg;
                        end else begin
                            count_we        = 1'b1;
                            count_wdata     = hit_cnt_reg + CW'(1);
                            res_status_next = ST_EXISTING;
                            res_id_next     = hit_idx_reg;
                            res_cnt_next    = hit_cnt_reg + CW'(1);
                        end
                    end else if (fc_reg == '0) begin
                        res_status_next = ST_FULL;
                    end else begin
                        handle_we           = 1'b1;
                        count_we            = 1'b1;
                        count_waddr         = pop_id;
                        count_wdata         = CW'(1);
                        valid_next[pop_id]  = 1'b1;
                        fc_next             = fc_reg - FCW'(1);
                        if (fc_reg - FCW'(1) < low_mark_reg) begin
                            low_mark_next = fc_reg - FCW'(1);
                        end
                        res_status_next = ST_NEW;
                        res_id_next     = pop_id;
                        res_cnt_next    = CW'(1);
                    end
                end else begin
                    if (!found_reg) begin
                        res_status_next = ST_UNKNOWN;
                    end else begin
                        count_we     = 1'b1;
                        count_wdata  = dec_cnt;
                        res_id_next  = hit_idx_reg;
                        res_cnt_next = dec_cnt;
                        if (dec_cnt == '0) begin
                            valid_next[hit_idx_reg] = 1'b0;
                            if (fc_reg < ALL_FREE) begin
                                stack_we = 1'b1;
                                fc_next  = fc_reg + FCW'(1);
                            end
                            res_status_next = ST_FREED;
                        end else begin
                            res_status_next = ST_HELD;
                        end
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cmp_vld_reg  <= 1'b0;
            valid_reg    <= '0;
            fc_reg       <= ALL_FREE;
            low_mark_reg <= ALL_FREE;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cmp_vld_reg  <= cmp_vld_next;
            valid_reg    <= valid_next;
            fc_reg       <= fc_next;
            low_mark_reg <= low_mark_next;
            if (state_reg == S_OUT && out_free) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_tuser[0];
            handle_reg <= HW'(s_tdata);
        end
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= scan_idx_reg;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_cnt_reg    <= hit_cnt_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        res_cnt_reg    <= res_cnt_next;
        if (state_reg == S_OUT && out_free) begin
            out_id_reg     <= res_id_reg;
            out_status_reg <= res_status_reg;
            out_cnt_reg    <= res_cnt_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, OUT_COUNT_BITS'(out_cnt_reg), OUT_ID_BITS'(out_id_reg)};

    // Every id is either on the free stack or owned by exactly one valid entry.
    a_ids_conserved: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(valid_reg) + int'(fc_reg)) == MAX_IDS)
        else $error("valid entries and free count do not add up to the id range");

    a_free_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (fc_reg <= ALL_FREE) && (low_mark_reg <= fc_reg))
        else $error("free count or low mark out of range");

    // An id taken from the free stack must not already be in use.
    a_pop_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |-> !valid_reg[pop_id])
        else $error("popped id is already owned by a valid entry");

    // A result is loaded only after a request has passed its decision step.
    a_result_follows_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> $past(state_reg == S_DECIDE) || $past(state_reg == S_OUT))
        else $error("output step entered without a decision");

endmodule

>>> bench/tb_refcounted_id_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_id_allocator.
// Depends on rcid_pkg and the allocator RTL; a predictor of the id table and
// free stack checks every result transfer on the m_ stream.
module tb_refcounted_id_allocator;
    import rcid_pkg::*;

    localparam int NUM_IDS    = 64;
    localparam int POOL_SIZE  = 96;
    localparam int HOLD_OFF   = 400;
    localparam int SETTLE     = 80;
    localparam int RAND_BLOCK = 200;

    typedef struct packed {
        logic [5:0]  id;
        status_t     status;
        logic [15:0] count;
    } alloc_result_t;

    typedef struct packed {
        logic          cmd;
        logic [31:0]   handle;
        logic          typed;
        alloc_result_t res;
    } stim_row_t;

    // Rows marked as typed carry a result that follows directly from reset
    // or an error code; the rest are left to the predictor.
    localparam stim_row_t DIRECTED [0:18] = '{
        '{CMD_RELEASE, 32'h0000_0000, 1'b1, '{6'd0, ST_UNKNOWN,  16'd0}},
        '{CMD_ACQUIRE, 32'hFFFF_FFFF, 1'b1, '{6'd0, ST_NEW,      16'd1}},
        '{CMD_ACQUIRE, 32'h0000_0000, 1'b1, '{6'd1, ST_NEW,      16'd1}},
        '{CMD_ACQUIRE, 32'h0000_0000, 1'b1, '{6'd1, ST_EXISTING, 16'd2}},
        '{CMD_RELEASE, 32'h0000_0000, 1'b0, '0},
        '{CMD_RELEASE, 32'h0000_0000, 1'b0, '0},
        '{CMD_RELEASE, 32'h0000_0000, 1'b1, '{6'd0, ST_UNKNOWN,  16'd0}},
        '{CMD_ACQUIRE, 32'hA5A5_A5A5, 1'b0, '0},
        '{CMD_ACQUIRE, 32'h5A5A_5A5A, 1'b0, '0},
        '{CMD_ACQUIRE, 32'h0000_0001, 1'b0, '0},
        '{CMD_RELEASE, 32'hA5A5_A5A5, 1'b0, '0},
        '{CMD_ACQUIRE, 32'h8000_0000, 1'b0, '0},
        '{CMD_RELEASE, 32'h5A5A_5A5A, 1'b0, '0},
        '{CMD_RELEASE, 32'h0000_0001, 1'b0, '0},
        '{CMD_ACQUIRE, 32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_RELEASE, 32'hFFFF_FFFE, 1'b1, '{6'd0, ST_UNKNOWN,  16'd0}},
        '{CMD_RELEASE, 32'h8000_0000, 1'b0, '0},
        '{CMD_RELEASE, 32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_ACQUIRE, 32'h0000_0000, 1'b0, '0}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = CMD_ACQUIRE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    // Predicted state of the handle table and the free stack.
    logic        tbl_valid  [NUM_IDS];
    logic [31:0] tbl_handle [NUM_IDS];
    logic [15:0] tbl_count  [NUM_IDS];
    logic [5:0]  free_ids   [NUM_IDS];
    int          free_depth;

    alloc_result_t expected_results[$];
    logic [31:0]   handle_pool [POOL_SIZE];

    bit idle_on     = 1'b1;
    int hold_asked  = 0;
    int hold_done   = 0;
    int hold_left   = 0;
    int errors      = 0;
    int sent_count  = 0;
    int status_seen [8];

    refcounted_id_allocator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("tb_refcounted_id_allocator: FAIL");
        $finish;
    end

    // Applies one request to the predicted table and returns its result.
    function automatic alloc_result_t apply_request(input logic cmd, input logic [31:0] handle);
        int            k;
        alloc_result_t r;
        r = '0;
        k = -1;
        for (int i = 0; i < NUM_IDS; i++) begin
            if (k < 0 && tbl_valid[i] && tbl_handle[i] == handle) k = i;
        end
        if (cmd == CMD_ACQUIRE) begin
            if (k >= 0) begin
                if (tbl_count[k] == '1) begin
                    r.status = ST_OVERFLOW;
                    r.count  = tbl_count[k];
                end else begin
                    tbl_count[k] = tbl_count[k] + 16'd1;
                    r.id     = 6'(k);
                    r.count  = tbl_count[k];
                    r.status = ST_EXISTING;
                end
            end else if (free_depth == 0) begin
                r.status = ST_FULL;
            end else begin
                free_depth          = free_depth - 1;
                r.id                = free_ids[free_depth];
                tbl_valid[r.id]     = 1'b1;
                tbl_handle[r.id]    = handle;
                tbl_count[r.id]     = 16'd1;
                r.count             = 16'd1;
                r.status            = ST_NEW;
            end
        end else begin
            if (k < 0) begin
                r.status = ST_UNKNOWN;
            end else begin
                r.id = 6'(k);
                if (tbl_count[k] != 0) tbl_count[k] = tbl_count[k] - 16'd1;
                r.count = tbl_count[k];
                if (r.count == 0) begin
                    tbl_valid[k] = 1'b0;
                    if (free_depth < NUM_IDS) begin
                        free_ids[free_depth] = 6'(k);
                        free_depth           = free_depth + 1;
                    end
                    r.status = ST_FREED;
                end else begin
                    r.status = ST_HELD;
                end
            end
        end
        return r;
    endfunction

    // Offers one request; s_tvalid is left high so back-to-back transfers
    // need no extra assignment.
    task automatic send_request(input logic cmd, input logic [31:0] handle,
                                input logic typed, input alloc_result_t typed_res);
        alloc_result_t r;
        if (idle_on && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= handle;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = apply_request(cmd, handle);
        sent_count++;
        expected_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    task automatic take_result();
        alloc_result_t want;
        alloc_result_t got;
        got.id     = m_tdata[5:0];
        got.count  = m_tdata[21:6];
        got.status = m_tuser;
        status_seen[got.status]++;
        if (expected_results.size() == 0) begin
            $error("result with no request outstanding: id %0d status %0d count %0d",
                   got.id, got.status, got.count);
            errors++;
        end else begin
            want = expected_results.pop_front();
            if (got.id != want.id) begin
                $error("assigned_id: expected %0d, got %0d", want.id, got.id);
                errors++;
            end
            if (got.status != want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.count != want.count) begin
                $error("ref_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
        end
    endtask

    // Result side: random back-pressure, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) take_result();
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (hold_asked != hold_done) begin
                hold_done <= hold_asked;
                hold_left <= HOLD_OFF;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= !(idle_on && $urandom_range(0, 99) < 12);
            end
        end
    end

    initial begin
        int          pick;
        logic        cmd;
        logic [31:0] handle;
        bit          filling;

        for (int i = 0; i < NUM_IDS; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_handle[i] = '0;
            tbl_count[i]  = '0;
            free_ids[i]   = 6'(NUM_IDS - 1 - i);
        end
        free_depth = NUM_IDS;
        for (int i = 0; i < 8; i++) status_seen[i] = 0;
        handle_pool[0] = 32'h0000_0000;
        handle_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) handle_pool[i] = $urandom;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i])
            send_request(DIRECTED[i].cmd, DIRECTED[i].handle, DIRECTED[i].typed,
                         DIRECTED[i].res);
        drain_results();

        // Fill the table past its capacity while the result side holds off.
        hold_asked <= hold_asked + 1;
        for (int i = 0; i < 72; i++)
            send_request(CMD_ACQUIRE, handle_pool[i], 1'b0, '0);

        // Random traffic in blocks that alternately fill and drain the table;
        // the second block runs with no idling on either side.
        for (int blk = 0; blk < 6; blk++) begin
            filling = (blk % 2 == 0);
            idle_on <= (blk != 1);
            for (int n = 0; n < RAND_BLOCK; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    cmd    = 1'($urandom_range(0, 1));
                    handle = $urandom;
                end else begin
                    handle = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
                    cmd    = ($urandom_range(0, 99) < (filling ? 70 : 30)) ?
                             CMD_ACQUIRE : CMD_RELEASE;
                end
                send_request(cmd, handle, 1'b0, '0);
            end
            if (blk == 2) drain_results();
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end

        $display("Ran %0d requests: directed cases from reset, a fill past capacity",
                 sent_count);
        $display("under a long receiver stall, then random acquire and release traffic.");
        $display("Results: new %0d, existing %0d, freed %0d, held %0d, full %0d, unknown %0d.",
                 status_seen[ST_NEW], status_seen[ST_EXISTING], status_seen[ST_FREED],
                 status_seen[ST_HELD], status_seen[ST_FULL], status_seen[ST_UNKNOWN]);
        if (errors == 0) begin
            $display("tb_refcounted_id_allocator: PASS");
        end else begin
            $display("tb_refcounted_id_allocator: FAIL");
        end
        $finish;
    end

endmodule
